// File: design/ar3_pkg.sv
// ----------------------------------------------------------------------------
// ar3_pkg: shared types and constants of the 3D axis rotation block
// Holds the axis codes, parameter defaults and the fixed-point constants of
// the sine evaluation (Q30 scale, Taylor divisors and their reciprocals).
// ----------------------------------------------------------------------------
package ar3_pkg;

  // Default parameter values.
  localparam int unsigned COORD_WIDTH_DEF    = 32;
  localparam int unsigned ANGLE_WIDTH_DEF    = 16;
  localparam int unsigned TRIG_FRAC_BITS_DEF = 15;

  // Rotation axis selector. The fourth code passes the point through.
  typedef enum logic [1:0] {
    AXIS_X = 2'd0,
    AXIS_Y = 2'd1,
    AXIS_Z = 2'd2
  } ar3_axis_e;

  // Q30 constants of the sine evaluation.
  localparam logic [30:0] Q30_ONE     = 31'h4000_0000;
  localparam logic [30:0] Q30_HALF    = 31'h2000_0000;
  localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;

  // Nested Taylor form: h = 1 - x^2 * h / k for k = 210, 156, 110, 72, 42, 20, 6.
  // Each division by k is done as a multiply by a rounded-up reciprocal and a
  // right shift, which is exact for dividends below 2^32.
  localparam int unsigned TAYLOR_TERMS = 7;

  localparam logic [7:0] TAYLOR_HALF [TAYLOR_TERMS] = '{
    8'd105, 8'd78, 8'd55, 8'd36, 8'd21, 8'd10, 8'd3
  };

  localparam int unsigned TAYLOR_SHIFT [TAYLOR_TERMS] = '{
    40, 40, 39, 39, 38, 37, 35
  };

  localparam logic [32:0] TAYLOR_RECIP [TAYLOR_TERMS] = '{
    33'(((64'd1 << 40) + 64'd209) / 64'd210),
    33'(((64'd1 << 40) + 64'd155) / 64'd156),
    33'(((64'd1 << 39) + 64'd109) / 64'd110),
    33'(((64'd1 << 39) + 64'd71) / 64'd72),
    33'(((64'd1 << 38) + 64'd41) / 64'd42),
    33'(((64'd1 << 37) + 64'd19) / 64'd20),
    33'(((64'd1 << 35) + 64'd5) / 64'd6)
  };

  // Register stages from angle to sine and cosine: fold, scale, square,
  // two per Taylor term, final product and rounding.
  localparam int unsigned SC_LATENCY = 5 + 2 * TAYLOR_TERMS;

endpackage

// File: design/ar3_in_if.sv
// ----------------------------------------------------------------------------
// ar3_in_if: input channel of the 3D axis rotation block
// Carries one point, its rotation axis and angle with a valid/ready pair.
// ----------------------------------------------------------------------------
interface ar3_in_if #(
  parameter int unsigned COORD_WIDTH = ar3_pkg::COORD_WIDTH_DEF,
  parameter int unsigned ANGLE_WIDTH = ar3_pkg::ANGLE_WIDTH_DEF
);

  logic                          valid;
  logic                          ready;
  logic [1:0]                    cmd;
  logic [ANGLE_WIDTH-1:0]        angle;
  logic signed [COORD_WIDTH-1:0] x_in;
  logic signed [COORD_WIDTH-1:0] y_in;
  logic signed [COORD_WIDTH-1:0] z_in;

  modport source (output valid, cmd, angle, x_in, y_in, z_in, input ready);
  modport sink   (input valid, cmd, angle, x_in, y_in, z_in, output ready);

endinterface

// File: design/ar3_out_if.sv
// ----------------------------------------------------------------------------
// ar3_out_if: output channel of the 3D axis rotation block
// Carries one rotated point with a valid/ready pair.
// ----------------------------------------------------------------------------
interface ar3_out_if #(
  parameter int unsigned COORD_WIDTH = ar3_pkg::COORD_WIDTH_DEF
);

  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] x_out;
  logic signed [COORD_WIDTH-1:0] y_out;
  logic signed [COORD_WIDTH-1:0] z_out;

  modport source (output valid, x_out, y_out, z_out, input ready);
  modport sink   (input valid, x_out, y_out, z_out, output ready);

endinterface

// File: design/axis_rotation_3d_top.sv
// ----------------------------------------------------------------------------
// axis_rotation_3d_top: rotation of one 3D point about the X, Y or Z axis
// Throughput: one point per cycle while the skid stage is empty; the
// sine/cosine pipeline does at most one multiply per stage and takes a new
// angle each cycle that it is enabled.
// Reset clears only the valid flags of the pipeline, output and skid stage.
// ----------------------------------------------------------------------------
module axis_rotation_3d_top #(
  parameter int unsigned COORD_WIDTH    = ar3_pkg::COORD_WIDTH_DEF,
  parameter int unsigned ANGLE_WIDTH    = ar3_pkg::ANGLE_WIDTH_DEF,
  parameter int unsigned TRIG_FRAC_BITS = ar3_pkg::TRIG_FRAC_BITS_DEF
) (
  input logic       clk_i,
  input logic       rst_ni,
  ar3_in_if.sink    in_if,
  ar3_out_if.source out_if
);
  import ar3_pkg::*;

  // Trig values are Q1.F with room for the sign and for exactly one.
  localparam int unsigned TW = TRIG_FRAC_BITS + 2;
  // Coordinate times trig value, and the sum of two such products.
  localparam int unsigned PW = COORD_WIDTH + TW;
  localparam int unsigned SW = PW + 1;

  localparam logic signed [SW-1:0] RND = SW'(1) << (TRIG_FRAC_BITS - 1);
  localparam logic signed [COORD_WIDTH-1:0] SAT_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
  localparam logic signed [COORD_WIDTH-1:0] SAT_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};
  localparam logic signed [TW-1:0] T_ONE = TW'(1) << TRIG_FRAC_BITS;

  typedef struct packed {
    logic [1:0]                    cmd;
    logic signed [COORD_WIDTH-1:0] x;
    logic signed [COORD_WIDTH-1:0] y;
    logic signed [COORD_WIDTH-1:0] z;
  } item_t;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] x;
    logic signed [COORD_WIDTH-1:0] y;
    logic signed [COORD_WIDTH-1:0] z;
  } coord3_t;

  // Rounds the sum of two products half up at the trig scale and saturates
  // it to the coordinate range.
  function automatic logic signed [COORD_WIDTH-1:0] round_sat(
    input logic signed [PW-1:0] pa,
    input logic signed [PW-1:0] pb
  );
    logic signed [SW-1:0]        sum;
    logic signed [SW-1:0]        shr;
    logic [SW-COORD_WIDTH:0]     hi_bits;
    logic signed [COORD_WIDTH-1:0] res;
    sum     = SW'(pa) + SW'(pb) + RND;
    shr     = sum >>> TRIG_FRAC_BITS;
    hi_bits = shr[SW-1:COORD_WIDTH-1];
    if (&hi_bits || ~|hi_bits) begin
      res = shr[COORD_WIDTH-1:0];
    end else if (shr[SW-1]) begin
      res = SAT_MIN;
    end else begin
      res = SAT_MAX;
    end
    return res;
  endfunction

  // The whole pipeline advances together whenever the skid stage is empty.
  // When the output is stalled, the item leaving the product stage drops
  // into the skid register, and only then does the input side stop. The
  // ready seen by the source is therefore a plain register.
  logic adv;
  logic skid_v_q;

  assign adv         = !skid_v_q;
  assign in_if.ready = adv;

  // Input register.
  logic                   in_v_q;
  item_t                  in_item_q;
  logic [ANGLE_WIDTH-1:0] in_angle_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else if (adv) begin
      in_v_q <= in_if.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      in_item_q  <= '{cmd: in_if.cmd, x: in_if.x_in, y: in_if.y_in, z: in_if.z_in};
      in_angle_q <= in_if.angle;
    end
  end

  // Sine and cosine of the angle, SC_LATENCY stages behind the input register.
  logic signed [TW-1:0] trig_s;
  logic signed [TW-1:0] trig_c;

  ar3_sincos #(
    .ANGLE_WIDTH   (ANGLE_WIDTH),
    .TRIG_FRAC_BITS(TRIG_FRAC_BITS)
  ) u_sincos (
    .clk_i  (clk_i),
    .en_i   (adv),
    .angle_i(in_angle_q),
    .sin_o  (trig_s),
    .cos_o  (trig_c)
  );

  // The point and axis travel alongside in a delay line of equal length.
  logic  dl_v_q    [SC_LATENCY];
  item_t dl_item_q [SC_LATENCY];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SC_LATENCY; i++) begin
        dl_v_q[i] <= 1'b0;
      end
    end else if (adv) begin
      dl_v_q[0] <= in_v_q;
      for (int i = 1; i < SC_LATENCY; i++) begin
        dl_v_q[i] <= dl_v_q[i-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dl_item_q[0] <= in_item_q;
      for (int i = 1; i < SC_LATENCY; i++) begin
        dl_item_q[i] <= dl_item_q[i-1];
      end
    end
  end

  // Product stage. Each rotated pair is a*c + b*(-s') and a*s' + b*c, where
  // a and b are the two coordinates off the axis and s' is the sine, negated
  // for the Y axis whose matrix has the sine terms the other way round.
  item_t                cur_item;
  logic signed [COORD_WIDTH-1:0] op_a;
  logic signed [COORD_WIDTH-1:0] op_b;
  logic signed [TW-1:0] ks;
  logic signed [TW-1:0] ks_neg;
  logic signed [PW-1:0] prod_d [4];

  assign cur_item = dl_item_q[SC_LATENCY-1];

  always_comb begin
    op_a = cur_item.x;
    op_b = cur_item.y;
    ks   = trig_s;
    unique case (ar3_axis_e'(cur_item.cmd))
      AXIS_X: begin
        op_a = cur_item.y;
        op_b = cur_item.z;
      end
      AXIS_Y: begin
        op_b = cur_item.z;
        ks   = -trig_s;
      end
      AXIS_Z: begin
      end
      default: begin
      end
    endcase
  end

  assign ks_neg    = -ks;
  assign prod_d[0] = PW'(op_a) * PW'(trig_c);
  assign prod_d[1] = PW'(op_b) * PW'(ks_neg);
  assign prod_d[2] = PW'(op_a) * PW'(ks);
  assign prod_d[3] = PW'(op_b) * PW'(trig_c);

  logic                 pv_q;
  item_t                p_item_q;
  logic signed [PW-1:0] prod_q [4];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q <= 1'b0;
    end else if (adv) begin
      pv_q <= dl_v_q[SC_LATENCY-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p_item_q <= cur_item;
      for (int i = 0; i < 4; i++) begin
        prod_q[i] <= prod_d[i];
      end
    end
  end

  // Sum, round and saturate, then place the results by axis. The coordinate
  // on the axis, and every coordinate for the unused selector, passes through.
  logic signed [COORD_WIDTH-1:0] dot0;
  logic signed [COORD_WIDTH-1:0] dot1;
  coord3_t                       res;

  assign dot0 = round_sat(prod_q[0], prod_q[1]);
  assign dot1 = round_sat(prod_q[2], prod_q[3]);

  always_comb begin
    res = '{x: p_item_q.x, y: p_item_q.y, z: p_item_q.z};
    unique case (ar3_axis_e'(p_item_q.cmd))
      AXIS_X: begin
        res.y = dot0;
        res.z = dot1;
      end
      AXIS_Y: begin
        res.x = dot0;
        res.z = dot1;
      end
      AXIS_Z: begin
        res.x = dot0;
        res.y = dot1;
      end
      default: begin
      end
    endcase
  end

  // Output register with a one-entry skid stage behind it.
  logic    out_take;
  logic    out_v_q;
  coord3_t out_q;
  coord3_t skid_q;

  assign out_take = !out_v_q || out_if.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (out_take) begin
      if (skid_v_q) begin
        out_v_q  <= 1'b1;
        skid_v_q <= 1'b0;
      end else begin
        out_v_q <= pv_q;
      end
    end else if (adv && pv_q) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_take) begin
      if (skid_v_q) begin
        out_q <= skid_q;
      end else begin
        out_q <= res;
      end
    end else if (adv) begin
      skid_q <= res;
    end
  end

  assign out_if.valid = out_v_q;
  assign out_if.x_out = out_q.x;
  assign out_if.y_out = out_q.y;
  assign out_if.z_out = out_q.z;

`ifndef SYNTHESIS
  // The skid stage only fills behind a held result.
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> out_v_q)
    else $error("skid register holds a result while the output register is empty");

  // A finished result that meets a stalled output must be caught by the skid.
  a_skid_catches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && !out_if.ready && !skid_v_q && pv_q) |=> skid_v_q)
    else $error("result lost while the output was stalled");

  // Sine and cosine of a live item never exceed one in magnitude.
  a_trig_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dl_v_q[SC_LATENCY-1] |-> (trig_s <= T_ONE) && (trig_s >= -T_ONE) &&
                             (trig_c <= T_ONE) && (trig_c >= -T_ONE))
    else $error("sine or cosine out of range");
`endif

endmodule

// File: design/ar3_sincos.sv
// ----------------------------------------------------------------------------
// ar3_sincos: pipelined fixed-point sine and cosine of a turn fraction
// Two lanes (sine, cosine) evaluate an odd Taylor polynomial in Q30 and
// round to Q1.TRIG_FRAC_BITS. At most one multiply per stage, SC_LATENCY stages.
// ----------------------------------------------------------------------------
module ar3_sincos #(
  parameter int unsigned ANGLE_WIDTH    = ar3_pkg::ANGLE_WIDTH_DEF,
  parameter int unsigned TRIG_FRAC_BITS = ar3_pkg::TRIG_FRAC_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           en_i,
  input  logic [ANGLE_WIDTH-1:0]         angle_i,
  output logic signed [TRIG_FRAC_BITS+1:0] sin_o,
  output logic signed [TRIG_FRAC_BITS+1:0] cos_o
);
  import ar3_pkg::*;

  localparam int unsigned TW  = TRIG_FRAC_BITS + 2;
  localparam int unsigned RSH = 30 - TRIG_FRAC_BITS;
  localparam int unsigned PAD = 32 - ANGLE_WIDTH;

  localparam logic [31:0]   RND_Q = 32'(1) << (RSH - 1);
  localparam logic [TW-1:0] T_ONE = TW'(1) << TRIG_FRAC_BITS;

  logic [1:0]           quad;
  logic [29:0]          rem;
  logic signed [TW-1:0] trig [2];

  // The two top angle bits give the quadrant; the rest is the offset in it.
  assign quad = angle_i[ANGLE_WIDTH-1 -: 2];
  assign rem  = 30'(angle_i[ANGLE_WIDTH-3:0]) << PAD;

  for (genvar l = 0; l < 2; l++) begin : g_lane
    logic [1:0]  lq;
    logic [30:0] r_q;
    logic        nr_q;
    logic [62:0] xp;
    logic [30:0] x_q;
    logic        nx_q;
    logic [61:0] x2p;
    logic [31:0] x2_q;
    logic [30:0] xa_q;
    logic        na_q;
    logic [31:0] t_q   [TAYLOR_TERMS];
    logic [31:0] x2t_q [TAYLOR_TERMS];
    logic [30:0] xt_q  [TAYLOR_TERMS];
    logic        nt_q  [TAYLOR_TERMS];
    logic [30:0] h_q   [TAYLOR_TERMS];
    logic [31:0] x2h_q [TAYLOR_TERMS];
    logic [30:0] xh_q  [TAYLOR_TERMS];
    logic        nh_q  [TAYLOR_TERMS];
    logic [61:0] sp;
    logic [30:0] s_q;
    logic        ns_q;
    logic [31:0] vs;
    logic [TW-1:0] vmag;
    logic [TW-1:0] vclip;
    logic signed [TW-1:0] v_q;

    // Cosine is the sine a quarter turn ahead.
    assign lq = quad + 2'(l);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q  <= lq[0] ? (Q30_ONE - 31'(rem)) : 31'(rem);
        nr_q <= lq[1];
      end
    end

    assign xp = 63'(r_q) * 63'(HALF_PI_Q30) + 63'(Q30_HALF);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        x_q  <= xp[60:30];
        nx_q <= nr_q;
      end
    end

    assign x2p = 62'(x_q) * 62'(x_q) + 62'(Q30_HALF);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        x2_q <= x2p[61:30];
        xa_q <= x_q;
        na_q <= nx_q;
      end
    end

    for (genvar i = 0; i < TAYLOR_TERMS; i++) begin : g_term
      logic [31:0] x2_prev;
      logic [30:0] x_prev;
      logic [30:0] h_prev;
      logic        n_prev;
      logic [62:0] tp;
      logic [31:0] nd;
      logic [64:0] qp;

      if (i == 0) begin : g_first
        assign x2_prev = x2_q;
        assign x_prev  = xa_q;
        assign h_prev  = Q30_ONE;
        assign n_prev  = na_q;
      end else begin : g_next
        assign x2_prev = x2h_q[i-1];
        assign x_prev  = xh_q[i-1];
        assign h_prev  = h_q[i-1];
        assign n_prev  = nh_q[i-1];
      end

      assign tp = 63'(x2_prev) * 63'(h_prev) + 63'(Q30_HALF);

      always_ff @(posedge clk_i) begin
        if (en_i) begin
          t_q[i]   <= tp[61:30];
          x2t_q[i] <= x2_prev;
          xt_q[i]  <= x_prev;
          nt_q[i]  <= n_prev;
        end
      end

      // Rounded division by the term divisor through its reciprocal.
      assign nd = t_q[i] + 32'(TAYLOR_HALF[i]);
      assign qp = 65'(nd) * 65'(TAYLOR_RECIP[i]);

      always_ff @(posedge clk_i) begin
        if (en_i) begin
          h_q[i]   <= Q30_ONE - 31'(qp >> TAYLOR_SHIFT[i]);
          x2h_q[i] <= x2t_q[i];
          xh_q[i]  <= xt_q[i];
          nh_q[i]  <= nt_q[i];
        end
      end
    end

    assign sp = 62'(xh_q[TAYLOR_TERMS-1]) * 62'(h_q[TAYLOR_TERMS-1]) + 62'(Q30_HALF);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        s_q  <= sp[60:30];
        ns_q <= nh_q[TAYLOR_TERMS-1];
      end
    end

    // Round to the output scale, limit to one and apply the quadrant sign.
    assign vs    = 32'(s_q) + RND_Q;
    assign vmag  = vs[31:RSH];
    assign vclip = (vmag > T_ONE) ? T_ONE : vmag;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        v_q <= ns_q ? -$signed(vclip) : $signed(vclip);
      end
    end

    assign trig[l] = v_q;
  end

  assign sin_o = trig[0];
  assign cos_o = trig[1];

endmodule
